[hw/rtl/anb_pkg.sv]
// Shared constants, types and helper functions of the Annex B NAL splitter.
package anb_pkg;

    localparam int SC_LEN = 4;
    localparam logic [31:0] SC_WORD = 32'h0100_0000;
    localparam int MAX_RESULTS = 5;
    localparam int RES_W = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 4;

    typedef logic [7:0] byte_t;

    // One queued job: an optional single payload byte, then an optional flushed tail.
    typedef struct packed {
        logic                     has_head;
        byte_t                    head_byte;
        logic                     head_first;
        logic                     head_last;
        logic [2:0]               tail_keep;
        logic [SC_LEN-1:0][7:0]   tail_bytes;
        logic                     tail_first;
        logic                     buf_end;
    } anb_job_t;

    function automatic byte_t sc_byte(input logic [1:0] k);
        return SC_WORD[{k, 3'b000} +: 8];
    endfunction

    function automatic logic is_sc(input byte_t a, input byte_t b, input byte_t c,
                                   input byte_t d);
        return (a == sc_byte(2'd0)) && (b == sc_byte(2'd1)) &&
               (c == sc_byte(2'd2)) && (d == sc_byte(2'd3));
    endfunction

endpackage

[hw/rtl/anb_in_if.sv]
// Byte stream channel carrying the encoded buffer.
interface anb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_last;

    modport source (output valid, output data_byte, output buffer_last, input ready);
    modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

[hw/rtl/anb_out_if.sv]
// NAL unit byte channel carrying the split units.
interface anb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] nal_byte;
    logic       byte_valid;
    logic       nal_first;
    logic       nal_last;
    logic       buffer_done;

    modport source (output valid, output nal_byte, output byte_valid, output nal_first,
                    output nal_last, output buffer_done, input ready);
    modport sink   (input valid, input nal_byte, input byte_valid, input nal_first,
                    input nal_last, input buffer_done, output ready);
endinterface

[hw/rtl/anb_front.sv]
// Front end: header check, lookahead window and start code detection.
module anb_front import anb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    anb_in_if.sink   buf_ch,
    output logic     job_valid,
    input  logic     job_ready,
    output anb_job_t job
);

    logic [2:0]             pos_reg, pos_next;
    logic                   bad_reg, bad_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   first_reg, first_next;
    logic [SC_LEN-1:0][7:0] la_reg, la_next;
    logic                   accept;
    logic                   flush_en;
    logic                   start_one;
    byte_t                  b;

    assign b            = buf_ch.data_byte;
    assign buf_ch.ready = job_ready;
    assign accept       = buf_ch.valid && job_ready;

    always_comb
    begin
        pos_next       = pos_reg;
        bad_next       = bad_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        la_next        = la_reg;
        job.has_head   = 1'b0;
        job.head_byte  = la_reg[0];
        job.head_first = first_reg;
        job.head_last  = 1'b0;

        if (pos_reg < 3'(SC_LEN))
        begin
            if (b != sc_byte(pos_reg[1:0]))
            begin
                bad_next = 1'b1;
            end
            pos_next = pos_reg + 3'd1;
        end
        else if (!bad_reg)
        begin
            if (cnt_reg < 3'(SC_LEN))
            begin
                la_next[cnt_reg[1:0]] = b;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(SC_LEN - 1) && is_sc(la_reg[0], la_reg[1], la_reg[2], b))
                begin
                    cnt_next = 3'd0;
                end
            end
            else if (is_sc(la_reg[1], la_reg[2], la_reg[3], b))
            begin
                job.has_head  = 1'b1;
                job.head_last = 1'b1;
                cnt_next      = 3'd0;
                first_next    = 1'b1;
            end
            else
            begin
                job.has_head = 1'b1;
                first_next   = 1'b0;
                la_next      = {b, la_reg[SC_LEN-1:1]};
            end
        end

        // The tail keeps everything before the first zero among the last three positions.
        flush_en  = buf_ch.buffer_last && (pos_next >= 3'(SC_LEN)) && !bad_next;
        start_one = (cnt_next == 3'(SC_LEN));
        job.tail_keep = cnt_next;
        for (int i = SC_LEN - 1; i >= 0; i--)
        begin
            if ((i != 0 || !start_one) && (3'(i) < cnt_next) && (la_next[i] == 8'h00))
            begin
                job.tail_keep = 3'(i);
            end
        end
        if (!flush_en)
        begin
            job.tail_keep = 3'd0;
        end
        job.tail_bytes = la_next;
        job.tail_first = first_next;
        job.buf_end    = buf_ch.buffer_last;
    end

    assign job_valid = buf_ch.valid && (job.has_head || buf_ch.buffer_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 3'd0;
            bad_reg   <= 1'b0;
            cnt_reg   <= 3'd0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (buf_ch.buffer_last)
            begin
                pos_reg   <= 3'd0;
                bad_reg   <= 1'b0;
                cnt_reg   <= 3'd0;
                first_reg <= 1'b1;
            end
            else
            begin
                pos_reg   <= pos_next;
                bad_reg   <= bad_next;
                cnt_reg   <= cnt_next;
                first_reg <= first_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            la_reg <= la_next;
        end
    end

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && buf_ch.buffer_last |=> pos_reg == 3'd0 && cnt_reg == 3'd0 && first_reg)
        else $error("front state not restored after the last byte of a buffer");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(SC_LEN))
        else $error("lookahead count beyond the window");

endmodule

[hw/rtl/anb_queue.sv]
// Short job queue decoupling the front end from the output sequencer.
module anb_queue import anb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  anb_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output anb_job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    anb_job_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond its depth");

endmodule

[hw/rtl/anb_back.sv]
// Back end: expands each queued job into result transactions through an output register.
module anb_back import anb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  anb_job_t  job,
    anb_out_if.source nal_ch
);

    logic [RES_W-1:0] idx_reg;
    logic             out_valid_reg;
    byte_t            byte_reg;
    logic             bvalid_reg;
    logic             first_reg;
    logic             last_reg;
    logic             done_reg;

    logic [RES_W-1:0] total;
    logic [RES_W-1:0] last_idx;
    logic [RES_W-1:0] j;
    logic             load;
    logic             final_res;
    byte_t            byte_next;
    logic             bvalid_next;
    logic             first_next;
    logic             last_next;

    assign total     = RES_W'(job.has_head) + RES_W'(job.tail_keep);
    assign last_idx  = (total == '0) ? '0 : total - RES_W'(1);
    assign final_res = (idx_reg == last_idx);
    assign load      = !out_valid_reg || nal_ch.ready;
    assign job_ready = load && final_res;
    assign j         = idx_reg - RES_W'(job.has_head);

    always_comb
    begin
        byte_next   = 8'h00;
        bvalid_next = 1'b0;
        first_next  = 1'b0;
        last_next   = 1'b0;
        if (job.has_head && idx_reg == '0)
        begin
            byte_next   = job.head_byte;
            bvalid_next = 1'b1;
            first_next  = job.head_first;
            last_next   = job.head_last;
        end
        else if (total != '0)
        begin
            byte_next   = job.tail_bytes[j[1:0]];
            bvalid_next = 1'b1;
            first_next  = job.tail_first && (j == '0);
            last_next   = ((j + RES_W'(1)) == RES_W'(job.tail_keep));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= job_valid;
            if (job_valid)
            begin
                idx_reg <= final_res ? '0 : idx_reg + RES_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
        begin
            byte_reg   <= byte_next;
            bvalid_reg <= bvalid_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            done_reg   <= job.buf_end && final_res;
        end
    end

    assign nal_ch.valid       = out_valid_reg;
    assign nal_ch.nal_byte    = byte_reg;
    assign nal_ch.byte_valid  = bvalid_reg;
    assign nal_ch.nal_first   = first_reg;
    assign nal_ch.nal_last    = last_reg;
    assign nal_ch.buffer_done = done_reg;

    a_marker_ends_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !bvalid_reg |-> done_reg && !first_reg && !last_reg)
        else $error("empty end marker outside the end of a buffer");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < RES_W'(MAX_RESULTS))
        else $error("result index beyond the results of one job");

endmodule

[hw/rtl/annexb_nal_splitter.sv]
// Top level of the Annex B NAL unit splitter.
//
//  Channel  Role  Transaction                                           
//  buf_ch   sink  data_byte, buffer_last                                
//  nal_ch   src   nal_byte, byte_valid, nal_first, nal_last, buffer_done
//
//  One byte is accepted every cycle while the job queue has room.
//  A buffer's final byte can release up to five result transactions, one per cycle while
//  ready, set by the output sequencer; the queue absorbs the flush while bytes keep arriving.
//  An accepted byte's first result passes through the queue memory and the output register.
//  Reset clears the header state, the window count and the queue; no clearing pass is needed.
module annexb_nal_splitter import anb_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    anb_in_if.sink    buf_ch,
    anb_out_if.source nal_ch
);

    logic     push_valid;
    logic     push_ready;
    anb_job_t push_job;
    logic     pop_valid;
    logic     pop_ready;
    anb_job_t pop_job;

    anb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .buf_ch    (buf_ch),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    anb_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    anb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .nal_ch    (nal_ch)
    );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the Annex B NAL unit splitter.
module testbench;
    import anb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 30;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        byte_t data;
        logic  valid;
        logic  first;
        logic  last;
        logic  done;
    } nal_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    anb_in_if  buf_if();
    anb_out_if nal_if();

    annexb_nal_splitter dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .buf_ch (buf_if),
        .nal_ch (nal_if)
    );

    nal_result_t nal_expect[$];
    byte_t       stream_q[$];

    logic [2:0]  hdr_seen;
    logic        hdr_broken;
    byte_t       window[SC_LEN];
    logic [2:0]  window_fill;
    logic        unit_opens;

    int          idle_pct;
    int          stall_pct;
    logic        hold_active;
    event        hold_go;
    int          mismatches;
    int          items_sent;
    int          cycles;

    always #(CLK_HALF) clk = ~clk;

    function automatic byte_t code_byte(input int k);
        return SC_WORD[8*k +: 8];
    endfunction

    function automatic logic start_code(input byte_t a, input byte_t b, input byte_t c,
                                        input byte_t d);
        return {a, b, c, d} == {code_byte(0), code_byte(1), code_byte(2), code_byte(3)};
    endfunction

    function automatic void expect_byte(input byte_t data, input logic first,
                                        input logic last);
        nal_result_t r;
        r.data  = data;
        r.valid = 1'b1;
        r.first = first;
        r.last  = last;
        r.done  = 1'b0;
        nal_expect.push_back(r);
    endfunction

    function automatic void clear_splitter();
        hdr_seen    = '0;
        hdr_broken  = 1'b0;
        window_fill = '0;
        unit_opens  = 1'b1;
        for (int i = 0; i < SC_LEN; i++)
            window[i] = '0;
    endfunction

    function automatic void shift_payload(input byte_t b);
        if (window_fill < SC_LEN)
        begin
            window[window_fill] = b;
            window_fill = window_fill + 1'b1;
            if (window_fill == SC_LEN && start_code(window[0], window[1], window[2], window[3]))
                window_fill = '0;
        end
        else if (start_code(window[1], window[2], window[3], b))
        begin
            expect_byte(window[0], unit_opens, 1'b1);
            window_fill = '0;
            unit_opens  = 1'b1;
        end
        else
        begin
            expect_byte(window[0], unit_opens, 1'b0);
            unit_opens = 1'b0;
            window[0] = window[1];
            window[1] = window[2];
            window[2] = window[3];
            window[3] = b;
        end
    endfunction

    function automatic void flush_window();
        int   fill;
        int   keep;
        logic found;
        fill  = window_fill;
        keep  = fill;
        found = 1'b0;
        for (int i = (fill == SC_LEN) ? 1 : 0; i < fill; i++)
        begin
            if (!found && window[i] == 8'h00)
            begin
                keep  = i;
                found = 1'b1;
            end
        end
        for (int i = 0; i < keep; i++)
            expect_byte(window[i], unit_opens && i == 0, i + 1 == keep);
    endfunction

    function automatic void predict_nal_bytes(input byte_t b, input logic last_in);
        int          size_at_entry;
        nal_result_t r;
        size_at_entry = nal_expect.size();
        if (hdr_seen < SC_LEN)
        begin
            if (b != code_byte(hdr_seen))
                hdr_broken = 1'b1;
            hdr_seen = hdr_seen + 1'b1;
        end
        else if (!hdr_broken)
        begin
            shift_payload(b);
        end
        if (last_in)
        begin
            if (hdr_seen >= SC_LEN && !hdr_broken)
                flush_window();
            if (nal_expect.size() == size_at_entry)
            begin
                r.data  = '0;
                r.valid = 1'b0;
                r.first = 1'b0;
                r.last  = 1'b0;
                r.done  = 1'b0;
                nal_expect.push_back(r);
            end
            r = nal_expect.pop_back();
            r.done = 1'b1;
            nal_expect.push_back(r);
            clear_splitter();
        end
    endfunction

    task automatic send_byte(input byte_t b, input logic last_in);
        while ($urandom_range(99) < idle_pct)
        begin
            buf_if.valid <= 1'b0;
            @(posedge clk);
        end
        buf_if.valid       <= 1'b1;
        buf_if.data_byte   <= b;
        buf_if.buffer_last <= last_in;
        @(posedge clk);
        while (!buf_if.ready)
            @(posedge clk);
        predict_nal_bytes(b, last_in);
        items_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_q[i])
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    function automatic byte_t pick_byte();
        int r;
        r = $urandom_range(7);
        if (r < 2)
            return 8'h00;
        if (r == 2)
            return code_byte(SC_LEN - 1);
        return byte_t'($urandom_range(255));
    endfunction

    function automatic void push_code();
        for (int k = 0; k < SC_LEN; k++)
            stream_q.push_back(code_byte(k));
    endfunction

    function automatic void build_valid_buffer();
        int units;
        int len;
        stream_q.delete();
        push_code();
        units = $urandom_range(4);
        for (int u = 0; u < units; u++)
        begin
            len = $urandom_range(9);
            for (int j = 0; j < len; j++)
                stream_q.push_back(pick_byte());
            if (u < units - 1 || $urandom_range(5) == 0)
                push_code();
        end
    endfunction

    function automatic void build_buffer();
        int len;
        int idx;
        if ($urandom_range(99) < 80)
        begin
            build_valid_buffer();
        end
        else
        begin
            case ($urandom_range(2))
                0:
                begin
                    stream_q.delete();
                    len = $urandom_range(1, 3);
                    for (int j = 0; j < len; j++)
                        stream_q.push_back(pick_byte());
                end
                1:
                begin
                    build_valid_buffer();
                    idx = $urandom_range(SC_LEN - 1);
                    stream_q[idx] = stream_q[idx] ^ byte_t'(1 << $urandom_range(7));
                end
                default:
                begin
                    stream_q.delete();
                    len = $urandom_range(1, 12);
                    for (int j = 0; j < len; j++)
                        stream_q.push_back(pick_byte());
                end
            endcase
        end
    endfunction

    task automatic run_random(input int target, input int sender_idle, input int receiver_stall);
        int start;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        start     = items_sent;
        while (items_sent - start < target)
        begin
            build_buffer();
            send_stream();
        end
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        stream_q = '{8'hFF};
        send_stream();
        stream_q = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_stream();
        stream_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01,
                     8'hFF, 8'h7F, 8'h00, 8'h01};
        send_stream();
        stream_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hAA};
        send_stream();
    endtask

    task automatic test_no_idle();
        run_random(80, 0, 0);
    endtask

    task automatic test_sender_idle();
        run_random(80, 46, 0);
    endtask

    task automatic test_receiver_stall();
        run_random(80, 0, 46);
    endtask

    task automatic test_both_idle();
        run_random(80, 27, 27);
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        -> hold_go;
        stream_q.delete();
        push_code();
        for (int j = 0; j < 40; j++)
            stream_q.push_back(byte_t'($urandom_range(1, 255)));
        send_stream();
    endtask

    initial
    begin
        buf_if.valid       = 1'b0;
        buf_if.data_byte   = '0;
        buf_if.buffer_last = 1'b0;
        nal_if.ready       = 1'b0;
        hold_active        = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        mismatches         = 0;
        items_sent         = 0;
        clear_splitter();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        buf_if.valid <= 1'b0;
        while (nal_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("annexb_nal_splitter test passed");
        else
            $display("annexb_nal_splitter test failed");
        $finish;
    end

    // The hold is timed on falling edges so that the receiver sees a settled value.
    initial
    begin
        forever
        begin
            @(hold_go);
            @(negedge clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_active = 1'b0;
        end
    end

    always @(posedge clk)
    begin : receive_side
        nal_result_t want;
        if (nal_if.valid && nal_if.ready)
        begin
            if (nal_expect.size() == 0)
            begin
                $error("unexpected transaction: nal_byte %h buffer_done %b",
                       nal_if.nal_byte, nal_if.buffer_done);
                mismatches++;
            end
            else
            begin
                want = nal_expect.pop_front();
                if (nal_if.nal_byte !== want.data)
                begin
                    $error("nal_byte: expected %h, actual %h", want.data, nal_if.nal_byte);
                    mismatches++;
                end
                if (nal_if.byte_valid !== want.valid)
                begin
                    $error("byte_valid: expected %b, actual %b", want.valid, nal_if.byte_valid);
                    mismatches++;
                end
                if (nal_if.nal_first !== want.first)
                begin
                    $error("nal_first: expected %b, actual %b", want.first, nal_if.nal_first);
                    mismatches++;
                end
                if (nal_if.nal_last !== want.last)
                begin
                    $error("nal_last: expected %b, actual %b", want.last, nal_if.nal_last);
                    mismatches++;
                end
                if (nal_if.buffer_done !== want.done)
                begin
                    $error("buffer_done: expected %b, actual %b", want.done,
                           nal_if.buffer_done);
                    mismatches++;
                end
            end
        end
        nal_if.ready <= hold_active ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("annexb_nal_splitter test failed");
                $finish;
            end
        end
    end

endmodule
